FILE: rtl/crcfd_pkg.sv
// shared types and constants of the crc-8 checked frame decoder
package crcfd_pkg;

    localparam int unsigned FrameBytes = 18;
    localparam int unsigned BodyBytes  = 17;
    localparam int unsigned CntW       = 5;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned RegCount   = 7;
    localparam int unsigned AddrW      = 5;
    localparam int unsigned DataW      = 32;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_CRC_POLY     = 3'd0,
        REG_CRC_INIT     = 3'd1,
        REG_CRC_XOR_OUT  = 3'd2,
        REG_REFLECT_IN   = 3'd3,
        REG_REFLECT_OUT  = 3'd4,
        REG_FRAME_START  = 3'd5,
        REG_COMMAND_CODE = 3'd6
    } t_reg_idx;

    localparam logic [7:0] RstCrcPoly     = 8'h07;
    localparam logic [7:0] RstCrcInit     = 8'h00;
    localparam logic [7:0] RstCrcXorOut   = 8'h00;
    localparam logic       RstReflectIn   = 1'b0;
    localparam logic       RstReflectOut  = 1'b0;
    localparam logic [7:0] RstFrameStart  = 8'hA5;
    localparam logic [7:0] RstCommandCode = 8'h07;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        line_idle;
        logic [31:0] arrival_time;
    } t_item;

    typedef struct packed {
        logic               target_tracked;
        logic [15:0]        sequence_res;
        logic signed [31:0] ball_position;
        logic signed [31:0] ball_velocity;
        logic [31:0]        source_time;
        logic [31:0]        receive_time;
    } t_result;

    typedef struct packed {
        logic [7:0] crc_poly;
        logic [7:0] crc_init;
        logic [7:0] crc_xor_out;
        logic       reflect_in;
        logic       reflect_out;
        logic [7:0] frame_start;
        logic [7:0] command_code;
    } t_crc_cfg;

    // queue status seen by the top level and the back
    typedef struct packed {
        logic full;
        logic avail;
    } t_q_stat;

endpackage

FILE: rtl/crcfd_front.sv
// front end: byte collection, running crc-8 and frame check
module crcfd_front
    import crcfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_item    i_item,
    input  t_crc_cfg i_cfg,
    output logic     o_push,
    output t_result  o_result
);

    logic [CntW-1:0] r_cnt, n_cnt;
    logic [7:0]      r_crc, n_crc;
    logic [7:0]      r_store [BodyBytes];

    logic [7:0] w_in, w_fin;
    logic       w_last;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

    function automatic logic [7:0] crc_upd(input logic [7:0] c0, input logic [7:0] poly);
        logic [7:0] c;
        c = c0;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    assign w_last = (r_cnt == CntW'(BodyBytes));
    assign w_in   = i_cfg.reflect_in ? rev8(i_item.data_byte) : i_item.data_byte;
    assign w_fin  = i_cfg.reflect_out ? rev8(r_crc ^ i_cfg.crc_xor_out)
                                      : (r_crc ^ i_cfg.crc_xor_out);

    always_comb begin
        n_cnt = r_cnt;
        n_crc = r_crc;
        if (i_accept) begin
            if (w_last) begin
                n_cnt = '0;
            end else begin
                n_crc = crc_upd(((r_cnt == '0) ? i_cfg.crc_init : r_crc) ^ w_in,
                                i_cfg.crc_poly);
                n_cnt = i_item.line_idle ? '0 : r_cnt + CntW'(1);
            end
        end
    end

    // frame passes when start, command and crc bytes all match
    assign o_push = i_accept && w_last &&
                    (r_store[0] == i_cfg.frame_start) &&
                    (r_store[1] == i_cfg.command_code) &&
                    (i_item.data_byte == w_fin);

    always_comb begin
        o_result.target_tracked = r_store[2][0];
        o_result.sequence_res   = {r_store[4], r_store[3]};
        o_result.ball_position  = {r_store[8], r_store[7], r_store[6], r_store[5]};
        o_result.ball_velocity  = {r_store[12], r_store[11], r_store[10], r_store[9]};
        o_result.source_time    = {r_store[16], r_store[15], r_store[14], r_store[13]};
        o_result.receive_time   = i_item.arrival_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        for (int k = 0; k < BodyBytes; k++) begin
            if (i_accept && (r_cnt == CntW'(k))) begin
                r_store[k] <= i_item.data_byte;
            end
        end
    end

endmodule

FILE: rtl/crcfd_fifo.sv
// short result queue between front and back
module crcfd_fifo
    import crcfd_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    input  logic    i_rd,
    output t_result o_data,
    output t_q_stat o_stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PtrW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            w_wr, w_rd;

    assign o_stat.full  = (r_cnt == CntW'(DEPTH));
    assign o_stat.avail = (r_cnt != '0);
    assign w_wr         = i_wr && !o_stat.full;
    assign w_rd         = i_rd && o_stat.avail;
    assign o_data       = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PtrW'(DEPTH - 1)) ? '0 : r_wp + PtrW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == PtrW'(DEPTH - 1)) ? '0 : r_rp + PtrW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/crcfd_back.sv
// back end: result output register
module crcfd_back
    import crcfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_stat,
    input  t_result i_data,
    output logic    o_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_rd     = i_stat.avail && (!r_valid || i_pop);
    assign o_empty  = !r_valid;
    assign o_result = r_data;

    always_comb begin
        n_valid = r_valid;
        if (o_rd) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_data <= i_data;
        end
    end

endmodule

FILE: rtl/crc8_checked_frame_decoder.sv
// top level: crc-8 checked 18-byte frame decoder with apb configuration
// a frame's result is queued as its 18th byte is taken, then loaded into the output register
// throughput: one byte per cycle while full is low; full rises only when the queue
//   holds DEPTH frames behind an output result that is not popped
// reset: synchronous active low; clears byte count, queue and output register,
//   and returns all configuration registers to their reset values
module crc8_checked_frame_decoder
    import crcfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // byte side
    input  logic             push,
    output logic             full,
    input  t_item            i_item,
    // result side
    output logic             empty,
    input  logic             pop,
    output t_result          o_result,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    t_crc_cfg r_cfg;
    t_reg_idx w_idx;
    logic     w_cfg_wr;

    logic     w_accept;
    logic     w_push;
    t_result  w_front_res;
    t_result  w_q_data;
    t_q_stat  w_q_stat;
    logic     w_q_rd;

    // register file: one register per word, index from paddr[4:2]
    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_poly     <= RstCrcPoly;
            r_cfg.crc_init     <= RstCrcInit;
            r_cfg.crc_xor_out  <= RstCrcXorOut;
            r_cfg.reflect_in   <= RstReflectIn;
            r_cfg.reflect_out  <= RstReflectOut;
            r_cfg.frame_start  <= RstFrameStart;
            r_cfg.command_code <= RstCommandCode;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_CRC_POLY:     r_cfg.crc_poly     <= pwdata[7:0];
                REG_CRC_INIT:     r_cfg.crc_init     <= pwdata[7:0];
                REG_CRC_XOR_OUT:  r_cfg.crc_xor_out  <= pwdata[7:0];
                REG_REFLECT_IN:   r_cfg.reflect_in   <= pwdata[0];
                REG_REFLECT_OUT:  r_cfg.reflect_out  <= pwdata[0];
                REG_FRAME_START:  r_cfg.frame_start  <= pwdata[7:0];
                REG_COMMAND_CODE: r_cfg.command_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back, unused address reads zero
    always_comb begin
        case (w_idx)
            REG_CRC_POLY:     prdata = {24'd0, r_cfg.crc_poly};
            REG_CRC_INIT:     prdata = {24'd0, r_cfg.crc_init};
            REG_CRC_XOR_OUT:  prdata = {24'd0, r_cfg.crc_xor_out};
            REG_REFLECT_IN:   prdata = {31'd0, r_cfg.reflect_in};
            REG_REFLECT_OUT:  prdata = {31'd0, r_cfg.reflect_out};
            REG_FRAME_START:  prdata = {24'd0, r_cfg.frame_start};
            REG_COMMAND_CODE: prdata = {24'd0, r_cfg.command_code};
            default:          prdata = '0;
        endcase
    end

    // bytes are held off only while the queue has no room
    assign full     = w_q_stat.full;
    assign w_accept = push && !full;

    // front: stores body bytes, runs the crc, checks the frame on its 18th byte
    crcfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_push   (w_push),
        .o_result (w_front_res)
    );

    // decouples the check from the output handshake
    crcfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_push),
        .i_data  (w_front_res),
        .i_rd    (w_q_rd),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    // back: output register refilled from the queue when it is empty or its result is popped
    crcfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_q_stat),
        .i_data   (w_q_data),
        .o_rd     (w_q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

FILE: rtl/crcfd_checker.sv
// port-level checks for the frame decoder, bound to the top level
module crcfd_checker
    import crcfd_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // output side comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // a result only appears after a taken byte has been queued and loaded into the output register
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full)) [*2] |=> empty)
        else $error("result appeared without an accepted byte");

    // the queue only fills behind a waiting result
    a_full_has_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full while no result is waiting");

    // a waiting result holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind crc8_checked_frame_decoder crcfd_checker u_crcfd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

FILE: tb/sv/crc8_frame_decode_checker.sv
// checker for the crc-8 checked frame decoder: predicts decoded frames and compares them
`timescale 1ns / 1ps
module crc8_frame_decode_checker
    import crcfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  t_item            i_item,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_result          i_result,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [AddrW-1:0] i_paddr,
    input  logic [DataW-1:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);

    t_crc_cfg   link_cfg;
    logic [4:0] body_count;
    logic [7:0] crc_acc;
    logic [7:0] body_bytes [0:BodyBytes-1];
    t_result    telemetry_due [$];
    int         mismatches = 0;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        int i;
        for (i = 0; i < 8; i++) r[i] = v[7 - i];
        return r;
    endfunction

    // msb-first shift register, one byte
    function automatic logic [7:0] crc_shift(input logic [7:0] base, input logic [7:0] b);
        logic [7:0] c;
        int i;
        c = base ^ (link_cfg.reflect_in ? mirror8(b) : b);
        for (i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ link_cfg.crc_poly) : (c << 1);
        return c;
    endfunction

    task automatic decode_byte(input t_item it);
        logic [7:0] base;
        logic [7:0] fin;
        t_result r;
        if (body_count < BodyBytes) begin
            base = (body_count == 0) ? link_cfg.crc_init : crc_acc;
            body_bytes[body_count] = it.data_byte;
            crc_acc = crc_shift(base, it.data_byte);
            body_count = it.line_idle ? 5'd0 : body_count + 5'd1;
        end else begin
            fin = crc_acc ^ link_cfg.crc_xor_out;
            if (link_cfg.reflect_out) fin = mirror8(fin);
            if (body_bytes[0] == link_cfg.frame_start &&
                body_bytes[1] == link_cfg.command_code &&
                it.data_byte == fin) begin
                r.target_tracked = body_bytes[2][0];
                r.sequence_res   = {body_bytes[4], body_bytes[3]};
                r.ball_position  = {body_bytes[8], body_bytes[7], body_bytes[6], body_bytes[5]};
                r.ball_velocity  = {body_bytes[12], body_bytes[11], body_bytes[10], body_bytes[9]};
                r.source_time    = {body_bytes[16], body_bytes[15], body_bytes[14], body_bytes[13]};
                r.receive_time   = it.arrival_time;
                telemetry_due.push_back(r);
            end
            body_count = 5'd0;
        end
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d in %s: expected %h, got %h", mismatches, label, want, got);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (telemetry_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: unexpected frame result %h", mismatches, got);
        end else begin
            want = telemetry_due.pop_front();
            compare_field("target_tracked", 32'(want.target_tracked), 32'(got.target_tracked));
            compare_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
            compare_field("ball_position", want.ball_position, got.ball_position);
            compare_field("ball_velocity", want.ball_velocity, got.ball_velocity);
            compare_field("source_time", want.source_time, got.source_time);
            compare_field("receive_time", want.receive_time, got.receive_time);
        end
    endtask

    task automatic write_register(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
        case (addr[AddrW-1:2])
            REG_CRC_POLY:     link_cfg.crc_poly     = data[7:0];
            REG_CRC_INIT:     link_cfg.crc_init     = data[7:0];
            REG_CRC_XOR_OUT:  link_cfg.crc_xor_out  = data[7:0];
            REG_REFLECT_IN:   link_cfg.reflect_in   = data[0];
            REG_REFLECT_OUT:  link_cfg.reflect_out  = data[0];
            REG_FRAME_START:  link_cfg.frame_start  = data[7:0];
            REG_COMMAND_CODE: link_cfg.command_code = data[7:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            link_cfg.crc_poly     = RstCrcPoly;
            link_cfg.crc_init     = RstCrcInit;
            link_cfg.crc_xor_out  = RstCrcXorOut;
            link_cfg.reflect_in   = RstReflectIn;
            link_cfg.reflect_out  = RstReflectOut;
            link_cfg.frame_start  = RstFrameStart;
            link_cfg.command_code = RstCommandCode;
            body_count = 5'd0;
            crc_acc    = RstCrcInit;
            telemetry_due.delete();
        end else begin
            if (i_pop && !i_empty) check_result(i_result);
            // a byte taken together with a write still sees the old setting
            if (i_push && !i_full) decode_byte(i_item);
            if (i_psel && i_penable && i_pwrite && i_pready) write_register(i_paddr, i_pwdata);
        end
        o_pending    <= telemetry_due.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/crc8_checked_frame_decoder_tb.sv
// testbench top of the crc-8 checked frame decoder: stimulus, pacing and verdict
`timescale 1ns / 1ps
module crc8_checked_frame_decoder_tb;
    import crcfd_pkg::*;

    localparam int StallLimit   = 4000;  // cycles with no handshake at all
    localparam int HoldCycles   = 300;   // long receiver hold-off
    localparam int TargetBytes  = 850;
    localparam int PhaseBytes   = 120;
    localparam int SettleCycles = 4;     // result reaches the output through the queue and the output register

    // receiver pacing styles
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_EVERY4,
        RX_SPARSE
    } t_rx_style;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push    = 1'b0;
    logic             full;
    t_item            i_item  = '0;
    logic             empty;
    logic             pop     = 1'b0;
    t_result          o_result;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [AddrW-1:0] paddr   = '0;
    logic [DataW-1:0] pwdata  = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    int fail_count;
    int pending;

    // clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    crc8_checked_frame_decoder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicts and compares decoded frames beside the block
    crc8_frame_decode_checker decode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ---------------------------------------------------------------
    // receiver: stalls on its own pattern, plus a long hold-off on request
    // ---------------------------------------------------------------
    int        hold_ticket  = 0;  // bumped by the stimulus to ask for a hold-off
    int        hold_served  = 0;
    int        hold_left    = 0;
    t_rx_style rx_style     = RX_FREE;
    int        rx_style_left = 0;
    int        rx_tick      = 0;

    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HoldCycles;
        end
        if (hold_left > 0) begin
            // counted here so the sender keeps pushing and the queue backs up
            hold_left--;
            pop <= 1'b0;
        end else begin
            if (rx_style_left == 0) begin
                rx_style      = t_rx_style'($urandom_range(0, 3));
                rx_style_left = $urandom_range(20, 120);
            end
            rx_style_left--;
            rx_tick++;
            case (rx_style)
                RX_FREE:   pop <= 1'b1;
                RX_COIN:   pop <= 1'($urandom_range(0, 1));
                RX_EVERY4: pop <= (rx_tick % 4 == 0);
                default:   pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // watchdog: ends the run after a long stretch with no handshake
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("crc8_checked_frame_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------
    t_crc_cfg   cfg_shadow;  // what the stimulus believes is programmed
    logic [7:0] frame_buf [0:FrameBytes-1];
    int         bytes_sent  = 0;
    int         burst_left  = 0;
    logic       steady      = 1'b0;  // no gaps while set

    function automatic logic [7:0] reverse_bits(input logic [7:0] v);
        logic [7:0] r;
        int i;
        for (i = 0; i < 8; i++) r[i] = v[7 - i];
        return r;
    endfunction

    // check byte for frame_buf under the current settings
    function automatic logic [7:0] frame_check_byte();
        logic [7:0] c;
        int k;
        int i;
        c = cfg_shadow.crc_init;
        for (k = 0; k < BodyBytes; k++) begin
            c = c ^ (cfg_shadow.reflect_in ? reverse_bits(frame_buf[k]) : frame_buf[k]);
            for (i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ cfg_shadow.crc_poly) : (c << 1);
        end
        c = c ^ cfg_shadow.crc_xor_out;
        return cfg_shadow.reflect_out ? reverse_bits(c) : c;
    endfunction

    // one item: bursts of random length with random gaps in between
    task automatic send_byte(input logic [7:0] b, input logic idle, input logic [31:0] t);
        t_item it;
        int gap;
        it.data_byte    = b;
        it.line_idle    = idle;
        it.arrival_time = t;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 60);
            if (gap > 0) begin
                @(negedge i_clk) push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_span(input int first, input int last, input logic idle_last);
        int i;
        for (i = first; i <= last; i++)
            send_byte(frame_buf[i], (i == last) ? idle_last : 1'b0, $urandom);
    endtask

    task automatic fill_good_frame();
        int i;
        frame_buf[0] = cfg_shadow.frame_start;
        frame_buf[1] = cfg_shadow.command_code;
        for (i = 2; i < BodyBytes; i++) frame_buf[i] = 8'($urandom_range(0, 255));
        frame_buf[FrameBytes-1] = frame_check_byte();
    endtask

    // sender stops and every expected frame has come out
    task automatic wait_drained();
        @(negedge i_clk) push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [AddrW-1:0] addr, input logic [7:0] val);
        logic [DataW-1:0] word;
        word      = $urandom;  // upper bits must be ignored
        word[7:0] = val;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        case (idx)
            REG_CRC_POLY:     cfg_shadow.crc_poly     = val;
            REG_CRC_INIT:     cfg_shadow.crc_init     = val;
            REG_CRC_XOR_OUT:  cfg_shadow.crc_xor_out  = val;
            REG_REFLECT_IN:   cfg_shadow.reflect_in   = val[0];
            REG_REFLECT_OUT:  cfg_shadow.reflect_out  = val[0];
            REG_FRAME_START:  cfg_shadow.frame_start  = val;
            REG_COMMAND_CODE: cfg_shadow.command_code = val;
            default: ;
        endcase
        apb_write({idx, 2'b00}, val);
    endtask

    task automatic set_config(input t_crc_cfg c);
        logic [7:0] noisy;
        write_reg(REG_CRC_POLY, c.crc_poly);
        write_reg(REG_CRC_INIT, c.crc_init);
        write_reg(REG_CRC_XOR_OUT, c.crc_xor_out);
        noisy = 8'($urandom_range(0, 255));
        noisy[0] = c.reflect_in;
        write_reg(REG_REFLECT_IN, noisy);
        noisy = 8'($urandom_range(0, 255));
        noisy[0] = c.reflect_out;
        write_reg(REG_REFLECT_OUT, noisy);
        write_reg(REG_FRAME_START, c.frame_start);
        write_reg(REG_COMMAND_CODE, c.command_code);
    endtask

    // mostly well-formed frames, with short bursts, broken frames and noise mixed in
    task automatic random_sequence();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            fill_good_frame();
            send_span(0, FrameBytes - 1, 1'($urandom_range(0, 1)));
        end else if (kind < 15) begin
            // short burst: line goes idle before the check byte
            fill_good_frame();
            n = $urandom_range(1, BodyBytes);
            send_span(0, n - 1, 1'b1);
        end else if (kind < 18) begin
            // start, command or check byte spoiled
            fill_good_frame();
            case ($urandom_range(0, 2))
                0:       i = 0;
                1:       i = 1;
                default: i = FrameBytes - 1;
            endcase
            frame_buf[i] = frame_buf[i] ^ 8'($urandom_range(1, 255));
            send_span(0, FrameBytes - 1, 1'($urandom_range(0, 1)));
        end else begin
            // noise, then an idle byte so the next frame starts aligned
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0), $urandom);
            send_byte(8'($urandom_range(0, 255)), 1'b1, $urandom);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        t_crc_cfg c;
        int       phase;
        int       phase_start;
        int       i;

        cfg_shadow.crc_poly     = RstCrcPoly;
        cfg_shadow.crc_init     = RstCrcInit;
        cfg_shadow.crc_xor_out  = RstCrcXorOut;
        cfg_shadow.reflect_in   = RstReflectIn;
        cfg_shadow.reflect_out  = RstReflectOut;
        cfg_shadow.frame_start  = RstFrameStart;
        cfg_shadow.command_code = RstCommandCode;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: frame with extreme field values, idle on the check byte
        frame_buf[0] = cfg_shadow.frame_start;
        frame_buf[1] = cfg_shadow.command_code;
        frame_buf[2] = 8'hFF;
        frame_buf[3] = 8'hFF;
        frame_buf[4] = 8'hFF;
        frame_buf[5] = 8'h00;
        frame_buf[6] = 8'h00;
        frame_buf[7] = 8'h00;
        frame_buf[8] = 8'h80;
        frame_buf[9] = 8'hFF;
        frame_buf[10] = 8'hFF;
        frame_buf[11] = 8'hFF;
        frame_buf[12] = 8'h7F;
        for (i = 13; i < BodyBytes; i++) frame_buf[i] = 8'hFF;
        frame_buf[FrameBytes-1] = frame_check_byte();
        for (i = 0; i < FrameBytes; i++)
            send_byte(frame_buf[i], (i == FrameBytes - 1),
                      (i == FrameBytes - 1) ? 32'hFFFF_FFFF : 32'h0);

        // directed: short burst of extreme bytes
        send_byte(8'h00, 1'b0, 32'h0);
        send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1, 32'h0);

        // init change in the middle of a frame leaves that frame alone
        wait_drained();
        fill_good_frame();
        send_span(0, 8, 1'b0);
        wait_drained();
        apb_write({REG_CRC_INIT, 2'b00}, cfg_shadow.crc_init ^ 8'h5A);
        cfg_shadow.crc_init = cfg_shadow.crc_init ^ 8'h5A;
        send_span(9, FrameBytes - 1, 1'b0);

        // start byte change in the middle of a frame rejects it
        wait_drained();
        fill_good_frame();
        send_span(0, 8, 1'b0);
        wait_drained();
        write_reg(REG_FRAME_START, cfg_shadow.frame_start ^ 8'h01);
        send_span(9, FrameBytes - 1, 1'b0);

        // address past the register list is ignored
        wait_drained();
        apb_write(AddrW'(RegCount * 4), 8'($urandom_range(0, 255)));

        phase = 0;
        while (bytes_sent < TargetBytes) begin
            wait_drained();
            case (phase)
                0: c = '0;
                1: begin
                    c = '1;
                end
                2: begin
                    // reflected crc-8 with the default frame header
                    c.crc_poly     = 8'h31;
                    c.crc_init     = 8'h00;
                    c.crc_xor_out  = 8'h00;
                    c.reflect_in   = 1'b1;
                    c.reflect_out  = 1'b1;
                    c.frame_start  = RstFrameStart;
                    c.command_code = RstCommandCode;
                end
                default: begin
                    c.crc_poly     = 8'($urandom_range(0, 255));
                    c.crc_init     = 8'($urandom_range(0, 255));
                    c.crc_xor_out  = 8'($urandom_range(0, 255));
                    c.reflect_in   = 1'($urandom_range(0, 1));
                    c.reflect_out  = 1'($urandom_range(0, 1));
                    c.frame_start  = 8'($urandom_range(0, 255));
                    c.command_code = 8'($urandom_range(0, 255));
                end
            endcase
            set_config(c);

            if (phase == 2) begin
                // receiver holds off while frames keep coming back to back
                hold_ticket++;
                steady = 1'b1;
                for (i = 0; i < 8; i++) begin
                    fill_good_frame();
                    send_span(0, FrameBytes - 1, 1'b0);
                end
                steady = 1'b0;
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PhaseBytes) random_sequence();
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("crc8_checked_frame_decoder verification clean");
        end else begin
            $display("crc8_checked_frame_decoder verification failed");
        end
        $finish;
    end

endmodule
